/* hdl/cdiv_pkg.sv */
// cdiv_pkg: widths, constants and the per-cell record of the complex divider.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cdiv_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int FRAC_BITS       = 16;
  localparam int OUT_WIDTH       = 32;

  // |x| of a cross sum and mag2 both stay at or below 2^(2*CW-1)
  localparam int XW     = 2 * COMPONENT_WIDTH;
  localparam int MW     = 2 * COMPONENT_WIDTH;
  localparam int SW     = 2 * COMPONENT_WIDTH + 2;
  // one cell per dividend bit of |x| * 2^FRAC_BITS
  localparam int NCELL  = XW + FRAC_BITS;
  // quotient bits kept; anything above is overflow anyway
  localparam int QW     = OUT_WIDTH + 1;

  localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
  localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (OUT_WIDTH - 1));

  typedef struct packed {
    logic [XW-1:0] x;     // dividend bits still to shift in
    logic [MW-1:0] r;     // partial remainder
    logic [QW-1:0] q;     // quotient so far
    logic          big;   // a quotient bit fell off the top
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t         re;
    lane_t         im;
    logic [MW-1:0] mag2;
    logic          zero;
    logic          last;
  } cell_t;

endpackage

/* hdl/cdiv_in_if.sv */
// cdiv_in_if: input channel, one bin per transaction.
// Depends on cdiv_pkg.
`timescale 1ns / 1ps

interface cdiv_in_if;
  logic valid;
  logic ready;
  logic signed [cdiv_pkg::COMPONENT_WIDTH-1:0] num_re;
  logic signed [cdiv_pkg::COMPONENT_WIDTH-1:0] num_im;
  logic signed [cdiv_pkg::COMPONENT_WIDTH-1:0] den_re;
  logic signed [cdiv_pkg::COMPONENT_WIDTH-1:0] den_im;
  logic last_in;

  modport source (output valid, num_re, num_im, den_re, den_im, last_in, input ready);
  modport sink   (input valid, num_re, num_im, den_re, den_im, last_in, output ready);
endinterface

/* hdl/cdiv_out_if.sv */
// cdiv_out_if: result channel, one quotient pair per transaction.
// Depends on cdiv_pkg.
`timescale 1ns / 1ps

interface cdiv_out_if;
  logic valid;
  logic ready;
  logic signed [cdiv_pkg::OUT_WIDTH-1:0] quot_re;
  logic signed [cdiv_pkg::OUT_WIDTH-1:0] quot_im;
  logic zero_den;
  logic saturated;
  logic last_out;

  modport source (output valid, quot_re, quot_im, zero_den, saturated, last_out,
                  input ready);
  modport sink   (input valid, quot_re, quot_im, zero_den, saturated, last_out,
                  output ready);
endinterface

/* hdl/cdiv_front.sv */
// cdiv_front: two stages; component products, then cross sums and mag2.
// Depends on cdiv_pkg.
`timescale 1ns / 1ps

module cdiv_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [cdiv_pkg::COMPONENT_WIDTH-1:0] num_re,
  input  logic [cdiv_pkg::COMPONENT_WIDTH-1:0] num_im,
  input  logic [cdiv_pkg::COMPONENT_WIDTH-1:0] den_re,
  input  logic [cdiv_pkg::COMPONENT_WIDTH-1:0] den_im,
  input  logic last_in,
  output logic o_valid,
  output cdiv_pkg::cell_t o
);
  localparam int CW = cdiv_pkg::COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = cdiv_pkg::SW;

  logic [CW-1:0] m_nr, m_ni, m_dr, m_di;
  logic [PW-1:0] p_nrdr, p_nidi, p_nidr, p_nrdi, p_drdr, p_didi;
  logic n_nrdr, n_nidi, n_nidr, n_nrdi;
  logic a_valid, a_last;
  logic signed [SW-1:0] s_re, s_im;
  logic [SW-1:0] a_re, a_im;
  logic [cdiv_pkg::MW:0] mag2_w;

  function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
    mag_of = v[CW-1] ? (~v + CW'(1)) : v;
  endfunction

  function automatic logic signed [SW-1:0] sgn(input logic [PW-1:0] m, input logic n);
    sgn = n ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  assign m_nr = mag_of(num_re);
  assign m_ni = mag_of(num_im);
  assign m_dr = mag_of(den_re);
  assign m_di = mag_of(den_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_nrdr <= m_nr * m_dr;
      p_nidi <= m_ni * m_di;
      p_nidr <= m_ni * m_dr;
      p_nrdi <= m_nr * m_di;
      p_drdr <= m_dr * m_dr;
      p_didi <= m_di * m_di;
      n_nrdr <= num_re[CW-1] ^ den_re[CW-1];
      n_nidi <= num_im[CW-1] ^ den_im[CW-1];
      n_nidr <= num_im[CW-1] ^ den_re[CW-1];
      // nr*di is subtracted
      n_nrdi <= ~(num_re[CW-1] ^ den_im[CW-1]);
      a_last <= last_in;
    end
  end

  assign s_re   = sgn(p_nrdr, n_nrdr) + sgn(p_nidi, n_nidi);
  assign s_im   = sgn(p_nidr, n_nidr) + sgn(p_nrdi, n_nrdi);
  assign a_re   = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
  assign a_im   = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
  assign mag2_w = {1'b0, p_drdr} + {1'b0, p_didi};

  always_ff @(posedge clk) begin
    if (en) begin
      o.re.x   <= a_re[cdiv_pkg::XW-1:0];
      o.re.r   <= '0;
      o.re.q   <= '0;
      o.re.big <= 1'b0;
      o.re.neg <= s_re[SW-1];
      o.im.x   <= a_im[cdiv_pkg::XW-1:0];
      o.im.r   <= '0;
      o.im.q   <= '0;
      o.im.big <= 1'b0;
      o.im.neg <= s_im[SW-1];
      o.mag2   <= mag2_w[cdiv_pkg::MW-1:0];
      o.zero   <= (mag2_w == '0);
      o.last   <= a_last;
    end
  end
endmodule

/* hdl/cdiv_cell.sv */
// cdiv_cell: one restoring-division step for both lanes, one quotient bit each.
// Depends on cdiv_pkg.
`timescale 1ns / 1ps

module cdiv_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic i_valid,
  input  cdiv_pkg::cell_t i,
  output logic o_valid,
  output cdiv_pkg::cell_t o
);
  localparam int MW = cdiv_pkg::MW;
  localparam int XW = cdiv_pkg::XW;
  localparam int QW = cdiv_pkg::QW;

  function automatic cdiv_pkg::lane_t step(input cdiv_pkg::lane_t l,
                                           input logic [MW-1:0] d);
    logic [MW:0] rs;
    logic        ge;
    logic [MW:0] rn;
    cdiv_pkg::lane_t n;
    rs      = {l.r, l.x[XW-1]};
    ge      = rs >= {1'b0, d};
    rn      = ge ? rs - {1'b0, d} : rs;
    n.r     = rn[MW-1:0];
    n.x     = {l.x[XW-2:0], 1'b0};
    n.q     = {l.q[QW-2:0], ge};
    n.big   = l.big | l.q[QW-1];
    n.neg   = l.neg;
    step    = n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o.re   <= step(i.re, i.mag2);
      o.im   <= step(i.im, i.mag2);
      o.mag2 <= i.mag2;
      o.zero <= i.zero;
      o.last <= i.last;
    end
  end
endmodule

/* hdl/cdiv_post.sv */
// cdiv_post: saturation, sign and zero-divisor handling; output register.
// Depends on cdiv_pkg.
`timescale 1ns / 1ps

module cdiv_post (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic i_valid,
  input  cdiv_pkg::cell_t i,
  output logic o_valid,
  output logic [cdiv_pkg::OUT_WIDTH-1:0] quot_re,
  output logic [cdiv_pkg::OUT_WIDTH-1:0] quot_im,
  output logic zero_den,
  output logic saturated,
  output logic last_out
);
  localparam int OW = cdiv_pkg::OUT_WIDTH;
  localparam int QW = cdiv_pkg::QW;

  logic clip_re, clip_im;
  logic [OW-1:0] v_re, v_im;

  function automatic logic is_clip(input cdiv_pkg::lane_t l);
    logic [QW-1:0] lim;
    lim     = l.neg ? cdiv_pkg::LIM_NEG : cdiv_pkg::LIM_POS;
    is_clip = l.big | (l.q > lim);
  endfunction

  function automatic logic [OW-1:0] final_val(input cdiv_pkg::lane_t l, input logic c);
    logic [QW-1:0] m;
    m         = c ? (l.neg ? cdiv_pkg::LIM_NEG : cdiv_pkg::LIM_POS) : l.q;
    final_val = l.neg ? (~m[OW-1:0] + OW'(1)) : m[OW-1:0];
  endfunction

  assign clip_re = is_clip(i.re);
  assign clip_im = is_clip(i.im);
  assign v_re    = final_val(i.re, clip_re);
  assign v_im    = final_val(i.im, clip_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_re   <= i.zero ? '0 : v_re;
      quot_im   <= i.zero ? '0 : v_im;
      zero_den  <= i.zero;
      saturated <= ~i.zero & (clip_re | clip_im);
      last_out  <= i.last;
    end
  end
endmodule

/* hdl/complex_divide_stream_unit.sv */
// Streaming complex divider: quot = num / den per spectrum bin, Q16.16 out,
// saturated, with zero-divisor flag. Accepts one transaction every clock
// cycle unless the output stalls. Stages: products and cross sums, one
// division cell per dividend bit (48 cells, each retiring one quotient bit
// of both parts), then saturation into the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so din.ready follows dout.ready.
// Depends on cdiv_pkg, cdiv_in_if, cdiv_out_if, cdiv_front, cdiv_cell, cdiv_post.
`timescale 1ns / 1ps

module complex_divide_stream_unit (
  input  logic clk,
  input  logic rst,
  cdiv_in_if.sink    din,
  cdiv_out_if.source dout
);
  localparam int NCELL = cdiv_pkg::NCELL;

  logic en;
  logic            cv [NCELL+1];
  cdiv_pkg::cell_t cd [NCELL+1];
  logic [cdiv_pkg::OUT_WIDTH-1:0] q_re, q_im;

  assign en        = ~dout.valid | dout.ready;
  assign din.ready = en;

  cdiv_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(din.valid),
    .num_re(din.num_re), .num_im(din.num_im),
    .den_re(din.den_re), .den_im(din.den_im),
    .last_in(din.last_in),
    .o_valid(cv[0]), .o(cd[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cdiv_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(cv[k]), .i(cd[k]),
      .o_valid(cv[k+1]), .o(cd[k+1])
    );
  end

  cdiv_post u_post (
    .clk(clk), .rst(rst), .en(en),
    .i_valid(cv[NCELL]), .i(cd[NCELL]),
    .o_valid(dout.valid),
    .quot_re(q_re), .quot_im(q_im),
    .zero_den(dout.zero_den), .saturated(dout.saturated),
    .last_out(dout.last_out)
  );

  assign dout.quot_re = $signed(q_re);
  assign dout.quot_im = $signed(q_im);
endmodule
